FILE: hw/rtl/stbp_pkg.sv
// Package for the song table byte parser.
// Holds the shared types, constants and the reciprocal table; no dependencies.
package stbp_pkg;

  localparam logic [7:0] TRACK_COUNT = 8'd254;
  localparam logic [8:0] SONG_ROWS   = 9'd256;
  localparam logic [7:0] GOTO_MARK   = 8'd254;
  localparam logic [3:0] MIN_COLS    = 4'd4;
  localparam logic [3:0] MAX_COLS    = 4'd8;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned PROD_W      = 16 + RECIP_W;

  typedef enum logic [1:0] {
    KIND_TRACK = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_GOTO  = 2'd2
  } stbp_kind_t;

  typedef enum logic [1:0] {
    REG_TRACK_COLUMNS = 2'd0,
    REG_BASE_ADDRESS  = 2'd1,
    REG_STREAM_LENGTH = 2'd2
  } stbp_reg_t;

  typedef struct packed {
    logic [3:0]  tr;
    logic [15:0] base;
    logic [15:0] len;
  } stbp_cfg_t;

  typedef struct packed {
    logic        is_goto;
    logic [7:0]  row;
    logic [2:0]  column;
    stbp_kind_t  kind;
    logic [7:0]  value;
    logic        fin;
    logic        d_neg;
    logic [15:0] d;
    logic [3:0]  tr;
    logic [15:0] len;
  } stbp_cmd_t;

  // ceil(2^19 / tr); exact quotient for 16-bit dividends, tr in 4..8
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] tr);
    logic [RECIP_W-1:0] m;
    unique case (tr)
      4'd5:    m = 18'd104858;
      4'd6:    m = 18'd87382;
      4'd7:    m = 18'd74899;
      4'd8:    m = 18'd65536;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/stbp_if.sv
// Valid/ready channel interfaces for the song table byte parser.
// Standalone; no package dependencies.
interface stbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       start_req;
  modport source (output valid, stream_byte, start_req, input ready);
  modport sink   (input valid, stream_byte, start_req, output ready);
endinterface

interface stbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] row;
  logic [2:0] column;
  logic [1:0] kind;
  logic [7:0] value;
  logic       finished;
  modport source (output valid, row, column, kind, value, finished, input ready);
  modport sink   (input valid, row, column, kind, value, finished, output ready);
endinterface

FILE: hw/rtl/stbp_front.sv
// Front end: per-byte parse state; each byte yields at most one write command.
// Depends on stbp_pkg.
module stbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        stream_byte,
  input  logic              start_req,
  input  stbp_pkg::stbp_cfg_t cfg,
  input  logic              q_space,
  output logic              q_push,
  output stbp_pkg::stbp_cmd_t q_cmd
);
  import stbp_pkg::*;

  logic [15:0] byte_index_r, byte_index_nxt, bi;
  logic [8:0]  row_index_r, row_index_nxt, ri;
  logic [2:0]  column_index_r, column_index_nxt, ci;
  logic [2:0]  goto_offset_r, goto_offset_nxt, go;
  logic        in_goto_r, in_goto_nxt, ig;
  logic [7:0]  vector_low_r, vector_low_nxt, vl;
  logic        done_r, done_nxt, dn;

  logic        fire;
  logic        push;
  logic        last;
  logic        fin;
  logic [3:0]  col_sum;
  logic [3:0]  off_sum;
  logic [8:0]  row_inc;
  logic [15:0] byte_inc;
  logic [16:0] diff;
  logic [17:0] line_end;

  assign in_ready = q_space;
  assign fire     = in_valid & q_space;
  assign q_push   = fire & push;

  always_comb begin
    bi = start_req ? '0 : byte_index_r;
    ri = start_req ? '0 : row_index_r;
    ci = start_req ? '0 : column_index_r;
    go = start_req ? '0 : goto_offset_r;
    ig = start_req ? 1'b0 : in_goto_r;
    vl = start_req ? '0 : vector_low_r;
    dn = start_req ? 1'b0 : done_r;

    byte_index_nxt   = bi;
    row_index_nxt    = ri;
    column_index_nxt = ci;
    goto_offset_nxt  = go;
    in_goto_nxt      = ig;
    vector_low_nxt   = vl;
    done_nxt         = dn;

    push     = 1'b0;
    fin      = 1'b0;
    off_sum  = '0;
    last     = ({1'b0, bi} + 17'd1) >= {1'b0, cfg.len};
    col_sum  = {1'b0, ci} + 4'd1;
    row_inc  = ri + 9'd1;
    byte_inc = bi + 16'd1;
    diff     = {1'b0, stream_byte, vl} - {1'b0, cfg.base};
    line_end = {2'b00, bi} + {14'd0, cfg.tr} - 18'd3;

    q_cmd         = '0;
    q_cmd.row     = ri[7:0];
    q_cmd.column  = ci;
    q_cmd.kind    = KIND_GOTO;
    q_cmd.tr      = cfg.tr;
    q_cmd.len     = cfg.len;
    q_cmd.d       = diff[15:0];
    q_cmd.d_neg   = diff[16];
    q_cmd.is_goto = 1'b1;

    if (dn) begin
      push = 1'b0;
    end else if (bi >= cfg.len) begin
      done_nxt = 1'b1;
    end else if (!ig && (stream_byte != GOTO_MARK || ci != 3'd0)) begin
      fin = last;
      if (col_sum >= cfg.tr) begin
        row_index_nxt    = row_inc;
        column_index_nxt = '0;
        if (row_inc >= SONG_ROWS) fin = 1'b1;
      end else begin
        column_index_nxt = col_sum[2:0];
      end
      byte_index_nxt = byte_inc;
      done_nxt       = fin;
      push           = 1'b1;
      q_cmd.is_goto  = 1'b0;
      q_cmd.kind     = (stream_byte < TRACK_COUNT) ? KIND_TRACK : KIND_EMPTY;
      q_cmd.value    = (stream_byte < TRACK_COUNT) ? stream_byte : 8'd0;
      q_cmd.fin      = fin;
    end else begin
      if (!ig) go = '0;
      in_goto_nxt     = 1'b1;
      goto_offset_nxt = go;
      off_sum         = {1'b0, go} + 4'd1;
      if (go < 3'd3) begin
        if (go == 3'd2) vector_low_nxt = stream_byte;
        if (last) begin
          push         = 1'b1;
          done_nxt     = 1'b1;
          q_cmd.column = '0;
          q_cmd.d_neg  = 1'b1;
          q_cmd.fin    = 1'b1;
        end else begin
          goto_offset_nxt = off_sum[2:0];
          byte_index_nxt  = byte_inc;
        end
      end else if (go == 3'd3) begin
        fin          = (line_end >= {2'b00, cfg.len}) || (row_inc >= SONG_ROWS);
        push         = 1'b1;
        done_nxt     = fin;
        q_cmd.column = '0;
        q_cmd.fin    = fin;
        if (!fin) begin
          row_index_nxt  = row_inc;
          byte_index_nxt = byte_inc;
          if (cfg.tr <= MIN_COLS) begin
            in_goto_nxt      = 1'b0;
            column_index_nxt = '0;
            goto_offset_nxt  = '0;
          end else begin
            goto_offset_nxt = 3'd4;
          end
        end
      end else begin
        byte_index_nxt = byte_inc;
        if (off_sum >= cfg.tr) begin
          in_goto_nxt      = 1'b0;
          column_index_nxt = '0;
          goto_offset_nxt  = '0;
        end else begin
          goto_offset_nxt = off_sum[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      row_index_r    <= '0;
      column_index_r <= '0;
      goto_offset_r  <= '0;
      in_goto_r      <= 1'b0;
      vector_low_r   <= '0;
      done_r         <= 1'b0;
    end else if (fire) begin
      byte_index_r   <= byte_index_nxt;
      row_index_r    <= row_index_nxt;
      column_index_r <= column_index_nxt;
      goto_offset_r  <= goto_offset_nxt;
      in_goto_r      <= in_goto_nxt;
      vector_low_r   <= vector_low_nxt;
      done_r         <= done_nxt;
    end
  end

endmodule

FILE: hw/rtl/stbp_fifo.sv
// Short command queue between the parser front end and the write back end.
// Depends on stbp_pkg.
module stbp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stbp_pkg::stbp_cmd_t din,
  output logic              space,
  input  logic              pop,
  output logic              valid,
  output stbp_pkg::stbp_cmd_t dout
);
  import stbp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  stbp_cmd_t         mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign space   = (count_r != FULL_CNT);
  assign valid   = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push & space;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/stbp_back.sv
// Back end: goto target divide by reciprocal multiply, range check, output register.
// Depends on stbp_pkg.
module stbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  stbp_pkg::stbp_cmd_t q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_row,
  output logic [2:0]        out_column,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_value,
  output logic              out_finished
);
  import stbp_pkg::*;

  localparam int unsigned QW = PROD_W - RECIP_SHIFT;

  logic              s1_valid_r, s1_valid_nxt;
  stbp_cmd_t         s1_cmd_r;
  logic [PROD_W-1:0] prod_q_r, prod_l_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_row_r, out_value_r;
  logic [2:0]        out_column_r;
  logic [1:0]        out_kind_r;
  logic              out_finished_r;

  logic              s1_adv, out_adv;
  logic [RECIP_W-1:0] m;
  logic [QW-1:0]     quot, lim;
  logic [7:0]        target;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign q_pop   = q_valid && s1_adv;
  assign m       = recip(q_cmd.tr);

  assign quot   = prod_q_r[PROD_W-1:RECIP_SHIFT];
  assign lim    = prod_l_r[PROD_W-1:RECIP_SHIFT];
  assign target = (!s1_cmd_r.d_neg && quot < lim && quot < QW'(SONG_ROWS)) ?
                  quot[7:0] : 8'd0;

  assign s1_valid_nxt  = s1_adv ? q_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_cmd_r <= q_cmd;
      prod_q_r <= q_cmd.d * m;
      prod_l_r <= q_cmd.len * m;
    end
    if (out_adv) begin
      out_row_r      <= s1_cmd_r.row;
      out_column_r   <= s1_cmd_r.column;
      out_kind_r     <= s1_cmd_r.kind;
      out_value_r    <= s1_cmd_r.is_goto ? target : s1_cmd_r.value;
      out_finished_r <= s1_cmd_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_column   = out_column_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_value_r;
  assign out_finished = out_finished_r;

endmodule

FILE: hw/rtl/song_table_byte_parser_top.sv
// Song table byte parser top level: config registers, front end, queue, back end.
// Depends on stbp_pkg, stbp_if, stbp_front, stbp_fifo, stbp_back.
//
// Usage: bytes of a packed song-order stream arrive on in_ch (stream_byte,
// start_req); start_req marks byte zero of a new parse. Each byte yields at
// most one table write on out_ch (row, column, kind, value, finished).
// Config via APB: track_columns at 0x0, base_address at 0x4, stream_length
// at 0x8; write only while the parser is idle. Reads return stored values.
// Throughput: one byte per cycle while the command queue has space. A byte's
// write passes through the queue, then the multiply stage for the goto
// divide, then the output register. The divide is a reciprocal multiply.
// in_ch.ready drops only when the command queue is full; queue depth is
// QUEUE_DEPTH, so the input keeps flowing under an output stall until the
// queue fills. Reset (synchronous, rst_n low) empties the queue and pipeline and
// loads track_columns = 4, base_address = 0, stream_length = 0.
module song_table_byte_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  stbp_in_if.sink     in_ch,
  stbp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stbp_pkg::*;

  logic [3:0]  track_columns_r;
  logic [15:0] base_address_r;
  logic [15:0] stream_length_r;
  logic        wr_en;
  stbp_reg_t   reg_sel;
  stbp_cfg_t   cfg;

  logic        q_space, q_push, q_valid, q_pop;
  stbp_cmd_t   push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = stbp_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_columns_r <= MIN_COLS;
      base_address_r  <= '0;
      stream_length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TRACK_COLUMNS: track_columns_r <= pwdata[3:0];
        REG_BASE_ADDRESS:  base_address_r  <= pwdata[15:0];
        REG_STREAM_LENGTH: stream_length_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TRACK_COLUMNS: prdata = {28'd0, track_columns_r};
      REG_BASE_ADDRESS:  prdata = {16'd0, base_address_r};
      REG_STREAM_LENGTH: prdata = {16'd0, stream_length_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.base = base_address_r;
    cfg.len  = stream_length_r;
    if (track_columns_r < MIN_COLS)      cfg.tr = MIN_COLS;
    else if (track_columns_r > MAX_COLS) cfg.tr = MAX_COLS;
    else                                 cfg.tr = track_columns_r;
  end

  stbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .stream_byte (in_ch.stream_byte),
    .start_req   (in_ch.start_req),
    .cfg         (cfg),
    .q_space     (q_space),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  stbp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .space (q_space),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (head_cmd)
  );

  stbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (head_cmd),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_row      (out_ch.row),
    .out_column   (out_ch.column),
    .out_kind     (out_ch.kind),
    .out_value    (out_ch.value),
    .out_finished (out_ch.finished)
  );

endmodule

FILE: hw/rtl/stbp_checker.sv
// Port-level checks for the song table byte parser, bound to the top level.
// Depends on stbp_pkg.
module stbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_column,
  input logic [1:0] out_kind,
  input logic [7:0] out_value
);
  import stbp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("write dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("write offered right after reset");

  a_goto_col0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_GOTO |-> out_column == 3'd0)
    else $error("goto write off column zero");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_value == 8'd0)
    else $error("empty cell with nonzero value");

endmodule

bind song_table_byte_parser_top stbp_checker u_stbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_column (out_ch.column),
  .out_kind   (out_ch.kind),
  .out_value  (out_ch.value)
);
